// ===== hw/rtl/cwle_pkg.sv =====
// Shared types, constants and strip tables for the cell wireframe line emitter.
`default_nettype none
package cwle_pkg;

    localparam int VertexIndexBits = 32;
    localparam logic [31:0] VtxMask = (VertexIndexBits >= 32) ? 32'hFFFF_FFFF :
        32'((64'd1 << VertexIndexBits) - 64'd1);

    localparam int QueueDepth = 2;

    localparam logic [1:0] ActFixed     = 2'd0;
    localparam logic [1:0] ActPolyFirst = 2'd1;
    localparam logic [1:0] ActPolyNext  = 2'd2;

    localparam logic [2:0] ShapeHex  = 3'd3;
    localparam logic [2:0] ShapePoly = 3'd4;

    localparam logic [2:0] RegShowNormal  = 3'd0;
    localparam logic [2:0] RegShowGhost   = 3'd1;
    localparam logic [2:0] RegShapeEnable = 3'd2;
    localparam logic [2:0] RegFirstCell   = 3'd3;
    localparam logic [2:0] RegLastCell    = 3'd4;

    // bit 3 marks the end of a strip, bits 2:0 pick the corner
    localparam logic [3:0] StripCode [4][16] = '{
        '{4'h0, 4'h1, 4'h3, 4'h8, 4'h1, 4'h2, 4'hB, 4'h2,
          4'h8, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0},
        '{4'h0, 4'h1, 4'h4, 4'h8, 4'h1, 4'h2, 4'hC, 4'h2,
          4'h3, 4'hC, 4'h3, 4'h8, 4'h0, 4'h0, 4'h0, 4'h0},
        '{4'h0, 4'h1, 4'h2, 4'h0, 4'h3, 4'h4, 4'h5, 4'hB,
          4'h1, 4'hC, 4'h2, 4'hD, 4'h0, 4'h0, 4'h0, 4'h0},
        '{4'h0, 4'h1, 4'h2, 4'h3, 4'h0, 4'hC, 4'h5, 4'h6,
          4'h7, 4'h4, 4'h5, 4'h9, 4'h2, 4'hE, 4'h3, 4'hF}
    };
    localparam logic [3:0] StripLast [4] = '{4'd8, 4'd11, 4'd11, 4'd15};

    typedef struct packed {
        logic        show_normal;
        logic        show_ghost;
        logic [4:0]  shape_enable;
        logic [31:0] first_cell;
        logic [31:0] last_cell;
    } t_cfg;

    typedef struct packed {
        logic             is_poly;
        logic [1:0]       shape;
        logic             poly_end;
        logic [7:0][31:0] vtx;
    } t_entry;

endpackage
`default_nettype wire

// ===== hw/rtl/cwle_regs.sv =====
// APB configuration registers.
`default_nettype none
module cwle_regs (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cwle_pkg::t_cfg    o_cfg
);
    cwle_pkg::t_cfg r_cfg;
    logic           wr;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.show_normal  <= 1'b1;
            r_cfg.show_ghost   <= 1'b0;
            r_cfg.shape_enable <= 5'h1F;
            r_cfg.first_cell   <= 32'hFFFF_FFFF;
            r_cfg.last_cell    <= 32'hFFFF_FFFF;
        end else if (wr) begin
            case (paddr[4:2])
                cwle_pkg::RegShowNormal:  r_cfg.show_normal  <= pwdata[0];
                cwle_pkg::RegShowGhost:   r_cfg.show_ghost   <= pwdata[0];
                cwle_pkg::RegShapeEnable: r_cfg.shape_enable <= pwdata[4:0];
                cwle_pkg::RegFirstCell:   r_cfg.first_cell   <= pwdata;
                cwle_pkg::RegLastCell:    r_cfg.last_cell    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            cwle_pkg::RegShowNormal:  prdata = {31'd0, r_cfg.show_normal};
            cwle_pkg::RegShowGhost:   prdata = {31'd0, r_cfg.show_ghost};
            cwle_pkg::RegShapeEnable: prdata = {27'd0, r_cfg.shape_enable};
            cwle_pkg::RegFirstCell:   prdata = r_cfg.first_cell;
            cwle_pkg::RegLastCell:    prdata = r_cfg.last_cell;
            default:                  prdata = 32'd0;
        endcase
    end
endmodule
`default_nettype wire

// ===== hw/rtl/cwle_front.sv =====
// Front end: filters requests, tracks polyhedron faces, builds queue entries.
`default_nettype none
module cwle_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire cwle_pkg::t_cfg i_cfg,
    input  wire logic           i_accept,
    input  wire logic [1:0]     i_action,
    input  wire logic [30:0]    i_cell_number,
    input  wire logic           i_ghost,
    input  wire logic [2:0]     i_shape,
    input  wire logic [7:0][31:0] i_vtx,
    output logic                o_push,
    output cwle_pkg::t_entry    o_entry
);
    logic        r_face_open;
    logic [31:0] r_face_start;
    logic        n_face_open;
    logic [31:0] n_face_start;
    logic        passes;
    logic        is_fixed;
    logic        is_poly;
    logic        open_eff;
    logic        hit;
    logic [7:0][31:0] vm;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            vm[k] = i_vtx[k] & cwle_pkg::VtxMask;
        end
    end

    always_comb begin
        passes = (i_ghost ? i_cfg.show_ghost : i_cfg.show_normal)
               && (i_shape <= cwle_pkg::ShapePoly)
               && i_cfg.shape_enable[i_shape[2] ? 3'd4 : {1'b0, i_shape[1:0]}];
        if (!i_cfg.first_cell[31] && ({1'b0, i_cell_number} < i_cfg.first_cell)) begin
            passes = 1'b0;
        end
        if (!i_cfg.last_cell[31] && ({1'b0, i_cell_number} > i_cfg.last_cell)) begin
            passes = 1'b0;
        end
    end

    assign is_fixed = passes && (i_action == cwle_pkg::ActFixed)
                    && (i_shape <= cwle_pkg::ShapeHex);
    assign is_poly  = passes && (i_shape == cwle_pkg::ShapePoly)
                    && ((i_action == cwle_pkg::ActPolyFirst)
                        || (i_action == cwle_pkg::ActPolyNext));
    assign open_eff = (i_action == cwle_pkg::ActPolyFirst) ? 1'b0 : r_face_open;
    assign hit      = open_eff && (vm[0] == r_face_start);

    always_comb begin
        n_face_open  = r_face_open;
        n_face_start = r_face_start;
        if (i_accept && is_poly) begin
            if (hit) begin
                n_face_open = 1'b0;
            end else if (!open_eff) begin
                n_face_open  = 1'b1;
                n_face_start = vm[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_open  <= 1'b0;
            r_face_start <= 32'd0;
        end else begin
            r_face_open  <= n_face_open;
            r_face_start <= n_face_start;
        end
    end

    assign o_push           = i_accept && (is_fixed || is_poly);
    assign o_entry.is_poly  = is_poly;
    assign o_entry.shape    = i_shape[1:0];
    assign o_entry.poly_end = hit;
    assign o_entry.vtx      = vm;
endmodule
`default_nettype wire

// ===== hw/rtl/cwle_queue.sv =====
// Short queue between front and back ends.
`default_nettype none
module cwle_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire cwle_pkg::t_entry i_entry,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output cwle_pkg::t_entry      o_head
);
    localparam int Depth = cwle_pkg::QueueDepth;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = $clog2(Depth + 1);

    cwle_pkg::t_entry r_mem [Depth];
    logic [PtrW-1:0]  r_wr;
    logic [PtrW-1:0]  r_rd;
    logic [CntW-1:0]  r_cnt;

    assign o_full  = (r_cnt == CntW'(Depth));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CntW'(i_push) - CntW'(i_pop);
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/cwle_back.sv =====
// Back end: walks strip tables and drives the result register.
`default_nettype none
module cwle_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_empty,
    input  wire cwle_pkg::t_entry i_head,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [31:0]           o_corner,
    output logic                  o_line_end,
    output logic                  o_last
);
    logic             r_busy;
    logic [3:0]       r_idx;
    cwle_pkg::t_entry r_cur;
    logic             r_out_valid;
    logic [31:0]      r_corner;
    logic             r_line_end;
    logic             r_last;

    cwle_pkg::t_entry src;
    logic             src_valid;
    logic [3:0]       idx;
    logic [3:0]       code;
    logic             src_last;
    logic             fire;

    assign src       = r_busy ? r_cur : i_head;
    assign src_valid = r_busy | ~i_empty;
    assign idx       = r_busy ? r_idx : 4'd0;
    assign code      = cwle_pkg::StripCode[src.shape][idx];
    assign src_last  = src.is_poly | (idx == cwle_pkg::StripLast[src.shape]);
    assign fire      = src_valid & (~r_out_valid | i_ready);
    assign o_pop     = fire & ~r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_out_valid <= 1'b1;
                r_busy      <= ~src_last;
                r_idx       <= idx + 4'd1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_corner   <= src.is_poly ? src.vtx[0] : src.vtx[code[2:0]];
            r_line_end <= src.is_poly ? src.poly_end : code[3];
            r_last     <= src_last;
            if (!r_busy) begin
                r_cur <= i_head;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_corner   = r_corner;
    assign o_line_end = r_line_end;
    assign o_last     = r_last;

    a_busy_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx != 4'd0)) else $error("busy with zero index");
    a_busy_fixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_cur.is_poly) else $error("polyhedron entry held busy");
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && src_last) |=> (!r_busy && r_last && r_out_valid))
        else $error("last result did not release entry");
endmodule
`default_nettype wire

// ===== hw/rtl/cell_wireframe_line_emitter.sv =====
// Top level of the cell wireframe line emitter.
//  channel   | handshake          | payload
//  request   | i_valid / o_ready  | action, cell_number, ghost, shape, vertex_0..7
//  result    | o_valid / i_ready  | corner, line_end, last
//  config    | APB psel/penable   | five registers at 4*i
// A tet gives 9 results, pyramid and prism 12, hex 16, a polyhedron corner 1,
// one per cycle from the back end's strip walker while i_ready is high; that sets the cell rate.
// Requests enter each cycle while the two-entry queue has room; filtered ones vanish.
// Reset is synchronous and active low; it closes any open face and empties the queue.
// Result stalls back up through the queue to o_ready.
`default_nettype none
module cell_wireframe_line_emitter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_action,
    input  wire logic [30:0] i_cell_number,
    input  wire logic        i_ghost,
    input  wire logic [2:0]  i_shape,
    input  wire logic [31:0] i_vertex_0,
    input  wire logic [31:0] i_vertex_1,
    input  wire logic [31:0] i_vertex_2,
    input  wire logic [31:0] i_vertex_3,
    input  wire logic [31:0] i_vertex_4,
    input  wire logic [31:0] i_vertex_5,
    input  wire logic [31:0] i_vertex_6,
    input  wire logic [31:0] i_vertex_7,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_corner,
    output logic             o_line_end,
    output logic             o_last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    cwle_pkg::t_cfg   cfg;
    cwle_pkg::t_entry entry;
    cwle_pkg::t_entry head;
    logic             push;
    logic             pop;
    logic             full;
    logic             empty;
    logic [7:0][31:0] vtx;

    assign vtx = {i_vertex_7, i_vertex_6, i_vertex_5, i_vertex_4,
                  i_vertex_3, i_vertex_2, i_vertex_1, i_vertex_0};
    assign o_ready = ~full;

    cwle_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cwle_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_accept      (i_valid & ~full),
        .i_action      (i_action),
        .i_cell_number (i_cell_number),
        .i_ghost       (i_ghost),
        .i_shape       (i_shape),
        .i_vtx         (vtx),
        .o_push        (push),
        .o_entry       (entry)
    );

    cwle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    cwle_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_head     (head),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_corner   (o_corner),
        .o_line_end (o_line_end),
        .o_last     (o_last)
    );
endmodule
`default_nettype wire
